@@ rtl/core/smx_pkg.sv @@
// Shared constants, opcodes and helper types for the stack machine executor.
`default_nettype none
package smx_pkg;

   localparam int unsigned STACK_DEPTH    = 64;
   localparam int unsigned VARIABLE_COUNT = 64;
   localparam int unsigned VALUE_WIDTH    = 32;

   localparam int unsigned STACK_AW = $clog2(STACK_DEPTH);
   localparam int unsigned DEPTH_W  = $clog2(STACK_DEPTH + 1);
   localparam int unsigned VAR_AW   = $clog2(VARIABLE_COUNT);
   localparam int unsigned COUNT_W  = $clog2(VALUE_WIDTH);

   localparam int unsigned MODE_W   = 5;
   localparam int unsigned LIT_W    = 32;
   localparam int unsigned INDEX_W  = 6;
   localparam int unsigned LABEL_W  = 16;
   localparam int unsigned ERR_W    = 2;
   localparam int unsigned REQ_W    = 64;
   localparam int unsigned RSP_W    = 56;

   typedef logic [VALUE_WIDTH-1:0] value_type;

   typedef enum logic [MODE_W-1:0] {
      OP_PUSH    = 5'd0,
      OP_RVALUE  = 5'd1,
      OP_LVALUE  = 5'd2,
      OP_POP     = 5'd3,
      OP_ASSIGN  = 5'd4,
      OP_PRINT   = 5'd5,
      OP_HALT    = 5'd6,
      OP_AND     = 5'd7,
      OP_OR      = 5'd8,
      OP_REM     = 5'd9,
      OP_ADD     = 5'd10,
      OP_SUB     = 5'd11,
      OP_MUL     = 5'd12,
      OP_DIV     = 5'd13,
      OP_NOT     = 5'd14,
      OP_NE      = 5'd15,
      OP_LE      = 5'd16,
      OP_GE      = 5'd17,
      OP_GT      = 5'd18,
      OP_LT      = 5'd19,
      OP_GOTO    = 5'd20,
      OP_GOFALSE = 5'd21
   } op_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE      = 2'd0,
      ERR_UNDERFLOW = 2'd1,
      ERR_OVERFLOW  = 2'd2,
      ERR_DIV_ZERO  = 2'd3
   } err_type;

   // Handshake between the sequencer and the divider.
   typedef struct packed {
      logic      start;
      value_type dividend;
      value_type divisor;
   } div_req_type;

   typedef struct packed {
      logic      done;
      value_type quotient;
      value_type remainder;
   } div_rsp_type;

endpackage
`default_nettype wire

@@ rtl/core/smx_stack_mem.sv @@
// Evaluation stack memory: entries below the cached top, one write and one registered read port.
`default_nettype none
module smx_stack_mem (
   input  wire                            clock,
   input  wire                            wr_en,
   input  wire [smx_pkg::STACK_AW-1:0]    wr_addr,
   input  wire smx_pkg::value_type        wr_data,
   input  wire [smx_pkg::STACK_AW-1:0]    rd_addr,
   output smx_pkg::value_type             rd_data
);

   smx_pkg::value_type mem [smx_pkg::STACK_DEPTH];
   smx_pkg::value_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/core/smx_var_store.sv @@
// Variable store memory with per-entry valid bits so unwritten variables read as zero.
`default_nettype none
module smx_var_store (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          wr_en,
   input  wire [smx_pkg::VAR_AW-1:0]    wr_addr,
   input  wire smx_pkg::value_type      wr_data,
   input  wire [smx_pkg::VAR_AW-1:0]    rd_addr,
   output smx_pkg::value_type           rd_data
);

   smx_pkg::value_type                   mem [smx_pkg::VARIABLE_COUNT];
   smx_pkg::value_type                   rd_data_ff;
   logic [smx_pkg::VARIABLE_COUNT-1:0]   valid_ff;
   logic                                 rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule
`default_nettype wire

@@ rtl/core/smx_div.sv @@
// Iterative unsigned divider, one quotient bit per cycle.
`default_nettype none
module smx_div (
   input  wire                        clock,
   input  wire                        reset,
   input  wire smx_pkg::div_req_type  req,
   output smx_pkg::div_rsp_type       rsp
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [smx_pkg::COUNT_W-1:0]       count_ff, count_in;
   smx_pkg::value_type                quot_ff, quot_in;
   smx_pkg::value_type                rem_ff, rem_in;
   smx_pkg::value_type                divisor_ff, divisor_in;
   logic [smx_pkg::VALUE_WIDTH:0]     shifted;
   logic [smx_pkg::VALUE_WIDTH:0]     trial;

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      shifted    = {rem_ff, quot_ff[smx_pkg::VALUE_WIDTH-1]};
      trial      = shifted - {1'b0, divisor_ff};
      if (req.start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         quot_in    = req.dividend;
         rem_in     = '0;
         divisor_in = req.divisor;
      end else if (busy_ff) begin
         if (!trial[smx_pkg::VALUE_WIDTH]) begin
            rem_in  = trial[smx_pkg::VALUE_WIDTH-1:0];
            quot_in = {quot_ff[smx_pkg::VALUE_WIDTH-2:0], 1'b1};
         end else begin
            rem_in  = shifted[smx_pkg::VALUE_WIDTH-1:0];
            quot_in = {quot_ff[smx_pkg::VALUE_WIDTH-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == smx_pkg::COUNT_W'(smx_pkg::VALUE_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quot_ff;
   assign rsp.remainder = rem_ff;

endmodule
`default_nettype wire

@@ rtl/core/stack_machine_executor.sv @@
// Top level of the stack machine executor: sequencer, ALU and result register.
`default_nettype none
// Each request transaction carries one instruction; each produces exactly one response
// transaction with the stack top after the step, print and jump indications, the halt
// status and an error code. The top of the stack is cached in a register and the
// entries below it live in a 64-entry synchronous memory; variables live in a second
// 64-entry memory whose entries read as zero until first assigned. An instruction
// passes through accept, execute with the memory read data and posting the response;
// assign adds a step because it needs a second stack read to refill the top, and div
// and rem wait while the divider produces one quotient bit per cycle. A new
// request is taken as soon as the sequencer is idle, even while the previous response
// still waits in the output register. Once halt has executed, later instructions leave
// all state untouched and report halted with no error.
module stack_machine_executor (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   // req_tdata from bit 0: mode[4:0], literal_value[36:5], variable_index[42:37],
   // label_target[58:43], zero fill[63:59].
   input  wire [smx_pkg::REQ_W-1:0]     req_tdata,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   // rsp_tdata from bit 0: top_value[31:0], print_valid[32], jump_taken[33],
   // jump_target[49:34], halted[50], error_code[52:51], zero fill[55:53].
   output logic [smx_pkg::RSP_W-1:0]    rsp_tdata
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_EXEC = 5'b00010,
      S_POP2 = 5'b00100,
      S_DIV  = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type                        state_ff, state_in;
   smx_pkg::op_type                  mode_ff, mode_in;
   smx_pkg::value_type               lit_ff, lit_in;
   logic [smx_pkg::INDEX_W-1:0]      vidx_ff, vidx_in;
   logic [smx_pkg::LABEL_W-1:0]      label_ff, label_in;
   logic [smx_pkg::DEPTH_W-1:0]      depth_ff, depth_in;
   smx_pkg::value_type               top_ff, top_in;
   logic                             halt_ff, halt_in;
   logic                             print_ff, print_in;
   logic                             jump_ff, jump_in;
   logic [smx_pkg::LABEL_W-1:0]      target_ff, target_in;
   smx_pkg::err_type                 err_ff, err_in;
   logic                             neg_q_ff, neg_q_in;
   logic                             neg_r_ff, neg_r_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [smx_pkg::RSP_W-1:0]        rsp_data_ff, rsp_data_in;

   logic                             req_accept;
   logic                             stk_wr_en;
   logic [smx_pkg::STACK_AW-1:0]     stk_wr_addr;
   smx_pkg::value_type               stk_wr_data;
   logic [smx_pkg::STACK_AW-1:0]     stk_rd_addr;
   smx_pkg::value_type               stk_rd_data;
   logic                             var_wr_en;
   logic [smx_pkg::VAR_AW-1:0]       var_wr_addr;
   logic [smx_pkg::VAR_AW-1:0]       var_rd_addr;
   smx_pkg::value_type               var_rd_data;
   smx_pkg::div_req_type             div_req;
   smx_pkg::div_rsp_type             div_rsp;

   smx_pkg::value_type               opa, opb, push_val, bin_res, mag_a, mag_b;
   logic [smx_pkg::DEPTH_W-1:0]      depth_m1, depth_m2, depth_m3;
   logic                             signed_lt, signed_gt;
   smx_pkg::value_type               top_out;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign depth_m1 = depth_ff - smx_pkg::DEPTH_W'(1);
   assign depth_m2 = depth_ff - smx_pkg::DEPTH_W'(2);
   assign depth_m3 = depth_ff - smx_pkg::DEPTH_W'(3);

   // The entry under the top is fetched while the instruction is accepted; assign
   // fetches one more entry down during execute to refill the top.
   assign stk_rd_addr = (state_ff == S_EXEC) ? depth_m3[smx_pkg::STACK_AW-1:0]
                                             : depth_m2[smx_pkg::STACK_AW-1:0];
   assign var_rd_addr = req_accept ? req_tdata[42:37] : vidx_ff;

   // Operands: the left one comes from memory, the right one is the cached top.
   assign opa       = stk_rd_data;
   assign opb       = top_ff;
   assign signed_lt = $signed(opa) < $signed(opb);
   assign signed_gt = $signed(opa) > $signed(opb);
   assign mag_a     = opa[smx_pkg::VALUE_WIDTH-1] ? (~opa + 1'b1) : opa;
   assign mag_b     = opb[smx_pkg::VALUE_WIDTH-1] ? (~opb + 1'b1) : opb;

   always_comb begin
      case (mode_ff)
         smx_pkg::OP_AND: bin_res = opa & opb;
         smx_pkg::OP_OR:  bin_res = opa | opb;
         smx_pkg::OP_ADD: bin_res = opa + opb;
         smx_pkg::OP_SUB: bin_res = opa - opb;
         smx_pkg::OP_MUL: bin_res = opa * opb;
         smx_pkg::OP_NE:  bin_res = smx_pkg::VALUE_WIDTH'(opa != opb);
         smx_pkg::OP_LE:  bin_res = smx_pkg::VALUE_WIDTH'(!signed_gt);
         smx_pkg::OP_GE:  bin_res = smx_pkg::VALUE_WIDTH'(!signed_lt);
         smx_pkg::OP_GT:  bin_res = smx_pkg::VALUE_WIDTH'(signed_gt);
         default:         bin_res = smx_pkg::VALUE_WIDTH'(signed_lt);
      endcase
   end

   always_comb begin
      case (mode_ff)
         smx_pkg::OP_RVALUE: push_val = var_rd_data;
         smx_pkg::OP_LVALUE: push_val = smx_pkg::VALUE_WIDTH'(vidx_ff);
         default:            push_val = lit_ff;
      endcase
   end

   assign top_out = (depth_ff == '0) ? '0 : top_ff;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      lit_in       = lit_ff;
      vidx_in      = vidx_ff;
      label_in     = label_ff;
      depth_in     = depth_ff;
      top_in       = top_ff;
      halt_in      = halt_ff;
      print_in     = print_ff;
      jump_in      = jump_ff;
      target_in    = target_ff;
      err_in       = err_ff;
      neg_q_in     = neg_q_ff;
      neg_r_in     = neg_r_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      stk_wr_en    = 1'b0;
      stk_wr_addr  = depth_m1[smx_pkg::STACK_AW-1:0];
      stk_wr_data  = top_ff;
      var_wr_en    = 1'b0;
      var_wr_addr  = opa[smx_pkg::VAR_AW-1:0];
      div_req.start    = 1'b0;
      div_req.dividend = mag_a;
      div_req.divisor  = mag_b;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               mode_in   = smx_pkg::op_type'(req_tdata[4:0]);
               lit_in    = req_tdata[36:5];
               vidx_in   = req_tdata[42:37];
               label_in  = req_tdata[58:43];
               print_in  = 1'b0;
               jump_in   = 1'b0;
               target_in = '0;
               err_in    = smx_pkg::ERR_NONE;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            if (!halt_ff) begin
               case (mode_ff) inside
                  smx_pkg::OP_PUSH, smx_pkg::OP_RVALUE, smx_pkg::OP_LVALUE: begin
                     if (depth_ff == smx_pkg::DEPTH_W'(smx_pkg::STACK_DEPTH)) begin
                        err_in = smx_pkg::ERR_OVERFLOW;
                     end else begin
                        // The old top moves down into memory.
                        stk_wr_en = (depth_ff != '0);
                        top_in    = push_val;
                        depth_in  = depth_ff + 1'b1;
                     end
                  end
                  smx_pkg::OP_POP: begin
                     if (depth_ff == '0) begin
                        err_in = smx_pkg::ERR_UNDERFLOW;
                     end else begin
                        top_in   = stk_rd_data;
                        depth_in = depth_m1;
                     end
                  end
                  smx_pkg::OP_ASSIGN: begin
                     if (depth_ff < smx_pkg::DEPTH_W'(2)) begin
                        err_in = smx_pkg::ERR_UNDERFLOW;
                     end else begin
                        // Indexes beyond the store are dropped but still popped.
                        var_wr_en = (opa[smx_pkg::VALUE_WIDTH-1:smx_pkg::VAR_AW] == '0);
                        depth_in  = depth_m2;
                        state_in  = S_POP2;
                     end
                  end
                  smx_pkg::OP_PRINT: begin
                     if (depth_ff == '0) begin
                        err_in = smx_pkg::ERR_UNDERFLOW;
                     end else begin
                        print_in = 1'b1;
                     end
                  end
                  smx_pkg::OP_HALT: begin
                     halt_in = 1'b1;
                  end
                  smx_pkg::OP_NOT: begin
                     if (depth_ff == '0) begin
                        err_in = smx_pkg::ERR_UNDERFLOW;
                     end else begin
                        top_in = smx_pkg::VALUE_WIDTH'(top_ff == '0);
                     end
                  end
                  smx_pkg::OP_GOTO: begin
                     jump_in   = 1'b1;
                     target_in = label_ff;
                  end
                  smx_pkg::OP_GOFALSE: begin
                     if (depth_ff == '0) begin
                        err_in = smx_pkg::ERR_UNDERFLOW;
                     end else begin
                        top_in   = stk_rd_data;
                        depth_in = depth_m1;
                        if (top_ff == '0) begin
                           jump_in   = 1'b1;
                           target_in = label_ff;
                        end
                     end
                  end
                  smx_pkg::OP_DIV, smx_pkg::OP_REM: begin
                     if (depth_ff < smx_pkg::DEPTH_W'(2)) begin
                        err_in = smx_pkg::ERR_UNDERFLOW;
                     end else if (opb == '0) begin
                        err_in = smx_pkg::ERR_DIV_ZERO;
                     end else begin
                        div_req.start = 1'b1;
                        neg_q_in = opa[smx_pkg::VALUE_WIDTH-1] ^ opb[smx_pkg::VALUE_WIDTH-1];
                        neg_r_in = opa[smx_pkg::VALUE_WIDTH-1];
                        state_in = S_DIV;
                     end
                  end
                  smx_pkg::OP_AND, smx_pkg::OP_OR, smx_pkg::OP_ADD, smx_pkg::OP_SUB,
                  smx_pkg::OP_MUL, smx_pkg::OP_NE, smx_pkg::OP_LE, smx_pkg::OP_GE,
                  smx_pkg::OP_GT, smx_pkg::OP_LT: begin
                     if (depth_ff < smx_pkg::DEPTH_W'(2)) begin
                        err_in = smx_pkg::ERR_UNDERFLOW;
                     end else begin
                        top_in   = bin_res;
                        depth_in = depth_m1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_POP2: begin
            top_in   = stk_rd_data;
            state_in = S_DONE;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               if (mode_ff == smx_pkg::OP_DIV) begin
                  top_in = neg_q_ff ? (~div_rsp.quotient + 1'b1) : div_rsp.quotient;
               end else begin
                  top_in = neg_r_ff ? (~div_rsp.remainder + 1'b1) : div_rsp.remainder;
               end
               depth_in = depth_m1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // Wait for the output register to free up before posting.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, err_ff, halt_ff, target_ff, jump_ff, print_ff, top_out};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         halt_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         halt_ff      <= halt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff     <= mode_in;
      lit_ff      <= lit_in;
      vidx_ff     <= vidx_in;
      label_ff    <= label_in;
      top_ff      <= top_in;
      print_ff    <= print_in;
      jump_ff     <= jump_in;
      target_ff   <= target_in;
      err_ff      <= err_in;
      neg_q_ff    <= neg_q_in;
      neg_r_ff    <= neg_r_in;
      rsp_data_ff <= rsp_data_in;
   end

   smx_stack_mem u_stack (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   smx_var_store u_vars (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (var_wr_en),
      .wr_addr (var_wr_addr),
      .wr_data (top_ff),
      .rd_addr (var_rd_addr),
      .rd_data (var_rd_data)
   );

   smx_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

`ifndef SYNTHESIS
   // The stack never holds more than its capacity.
   assert property (@(posedge clock) disable iff (reset)
      depth_ff <= smx_pkg::DEPTH_W'(smx_pkg::STACK_DEPTH))
      else $error("stack depth beyond capacity");

   // Once halted, the stack depth no longer changes.
   assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> $stable(depth_ff))
      else $error("stack changed after halt");

   // A response that reports an error never prints or jumps.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff[52:51] != smx_pkg::ERR_NONE)) |->
         (rsp_data_ff[33:32] == 2'b00))
      else $error("error response with print or jump");
`endif

endmodule
`default_nettype wire
